/* design/jlsp_pkg.sv */
// ----------------------------------------------------------------------------
// jlsp_pkg
// Shared codes and controller/datapath link types of the braking profile block
// ----------------------------------------------------------------------------
`default_nettype none

package jlsp_pkg;

   localparam int CFG_ADDR_BITS = 3;

   localparam logic REG_DECEL = 1'b0;
   localparam logic REG_JERK  = 1'b1;

   typedef logic [3:0] op_type;

   localparam op_type OP_ASQ   = 4'd0;
   localparam op_type OP_MRG_Q = 4'd1;
   localparam op_type OP_REL_Q = 4'd2;
   localparam op_type OP_HR    = 4'd3;
   localparam op_type OP_HA    = 4'd4;
   localparam op_type OP_MRG_S = 4'd5;
   localparam op_type OP_REL_S = 4'd6;
   localparam op_type OP_JD    = 4'd7;
   localparam op_type OP_ADT   = 4'd8;
   localparam op_type OP_JDD   = 4'd9;

   typedef struct packed {
      logic   load;
      logic   mul_start;
      logic   wb;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic mul_busy;
      logic out_free;
      logic advance;
   } status_type;

endpackage

`default_nettype wire

/* design/jlsp_req_if.sv */
// ----------------------------------------------------------------------------
// jlsp_req_if
// Request channel: load or step transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface jlsp_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [31:0] load_speed;
   logic signed [31:0] load_accel;
   logic signed [31:0] load_curvature;
   logic        [30:0] load_elapsed;
   logic        [30:0] step_time;

   modport source (output valid, opcode, load_speed, load_accel, load_curvature,
                   load_elapsed, step_time, input ready);
   modport sink (input valid, opcode, load_speed, load_accel, load_curvature,
                 load_elapsed, step_time, output ready);
endinterface

`default_nettype wire

/* design/jlsp_rsp_if.sv */
// ----------------------------------------------------------------------------
// jlsp_rsp_if
// Response channel: one profile sample per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface jlsp_rsp_if;
   logic               valid;
   logic               ready;
   logic        [30:0] out_speed;
   logic signed [31:0] out_accel;
   logic signed [31:0] out_jerk;
   logic signed [31:0] yaw_rate;
   logic signed [31:0] yaw_accel;
   logic               halt_flag;
   logic        [30:0] out_elapsed;
   logic               status;

   modport source (output valid, out_speed, out_accel, out_jerk, yaw_rate,
                   yaw_accel, halt_flag, out_elapsed, status, input ready);
   modport sink (input valid, out_speed, out_accel, out_jerk, yaw_rate,
                 yaw_accel, halt_flag, out_elapsed, status, output ready);
endinterface

`default_nettype wire

/* design/jlsp_csr.sv */
// ----------------------------------------------------------------------------
// jlsp_csr
// APB register file holding the deceleration and jerk limits
// ----------------------------------------------------------------------------
`default_nettype none

module jlsp_csr #(
   parameter logic [30:0] DECEL_RESET = 31'd393216,
   parameter logic [30:0] JERK_RESET  = 31'd655360
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [jlsp_pkg::CFG_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready,
   output logic      [30:0]                        decel_limit,
   output logic      [30:0]                        jerk_max
);

   logic [30:0] decel_ff, decel_in;
   logic [30:0] jerk_ff, jerk_in;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      decel_in = decel_ff;
      jerk_in  = jerk_ff;
      prdata   = '0;
      unique case (paddr[2])
         jlsp_pkg::REG_DECEL: begin
            if (wr_en) decel_in = pwdata[30:0];
            prdata = {1'b0, decel_ff};
         end
         jlsp_pkg::REG_JERK: begin
            if (wr_en) jerk_in = pwdata[30:0];
            prdata = {1'b0, jerk_ff};
         end
         default: prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decel_ff <= DECEL_RESET;
         jerk_ff  <= JERK_RESET;
      end else begin
         decel_ff <= decel_in;
         jerk_ff  <= jerk_in;
      end
   end

   assign decel_limit = decel_ff;
   assign jerk_max    = jerk_ff;

endmodule

`default_nettype wire

/* design/jlsp_mul.sv */
// ----------------------------------------------------------------------------
// jlsp_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module jlsp_mul #(
   parameter int MW = 32
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            start,
   input  wire logic [MW-1:0]   a,
   input  wire logic [MW-1:0]   b,
   output logic                 busy,
   output logic [2*MW-1:0]      prod
);

   localparam int CW = $clog2(MW + 1);

   logic [2*MW-1:0] p_ff, p_in;
   logic [MW-1:0]   a_ff, a_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [MW:0]     sum;

   always_comb begin
      sum     = {1'b0, p_ff[2*MW-1:MW]} + (p_ff[0] ? {1'b0, a_ff} : '0);
      p_in    = p_ff;
      a_in    = a_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         p_in    = {{MW{1'b0}}, b};
         a_in    = a;
         cnt_in  = CW'(MW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         p_in   = {sum, p_ff[MW-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      p_ff <= p_in;
      a_ff <= a_in;
   end

   assign busy = busy_ff;
   assign prod = p_ff;

endmodule

`default_nettype wire

/* design/jlsp_datapath.sv */
// ----------------------------------------------------------------------------
// jlsp_datapath
// Profile state, operand selection, shared multiplier and response register
// ----------------------------------------------------------------------------
`default_nettype none

module jlsp_datapath #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire jlsp_pkg::cmd_type   cmd,
   output jlsp_pkg::status_type     status,
   input  wire logic                opcode,
   input  wire logic signed [31:0]  load_speed,
   input  wire logic signed [31:0]  load_accel,
   input  wire logic signed [31:0]  load_curvature,
   input  wire logic        [30:0]  load_elapsed,
   input  wire logic        [30:0]  step_time,
   input  wire logic        [30:0]  decel_limit,
   input  wire logic        [30:0]  jerk_max,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic        [30:0]       out_speed,
   output logic signed [31:0]       out_accel,
   output logic signed [31:0]       out_jerk,
   output logic signed [31:0]       yaw_rate,
   output logic signed [31:0]       yaw_accel,
   output logic                     halt_flag,
   output logic        [30:0]       out_elapsed,
   output logic                     status_bit
);

   localparam int W   = WORD_BITS;
   localparam int F   = FRAC_BITS;
   localparam int MW  = (W > 32) ? W : 32;
   localparam int XW  = MW + 2;
   localparam int PW  = 2 * MW;
   localparam int Q001 = ((1 << F) + 50) / 100;

   localparam logic signed [XW-1:0] VMAX_X   = {{(XW-W+1){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [XW-1:0] VMIN_X   = ~VMAX_X;
   localparam logic signed [XW-1:0] O32MAX_X = {{(XW-31){1'b0}}, {31{1'b1}}};
   localparam logic signed [XW-1:0] O32MIN_X = ~O32MAX_X;
   localparam logic signed [XW-1:0] ONE_X    = XW'(1);
   localparam logic signed [XW-1:0] MONE_X   = '1;
   localparam logic signed [XW-1:0] ZERO_X   = '0;
   localparam logic [PW-1:0]        VMAX_P   = {{(PW-W+1){1'b0}}, {(W-1){1'b1}}};

   function automatic logic signed [XW-1:0] sx(input logic [W-1:0] v);
      return {{(XW-W){v[W-1]}}, v};
   endfunction

   function automatic logic signed [XW-1:0] sat_w(input logic signed [XW-1:0] v);
      if (v > VMAX_X) return VMAX_X;
      if (v < VMIN_X) return VMIN_X;
      return v;
   endfunction

   function automatic logic [31:0] sat_32(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] t;
      t = v;
      if (v > O32MAX_X) t = O32MAX_X;
      if (v < O32MIN_X) t = O32MIN_X;
      return t[31:0];
   endfunction

   function automatic logic [MW-1:0] mag(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] t;
      t = v[XW-1] ? -v : v;
      return t[MW-1:0];
   endfunction

   // profile state
   logic [W-1:0]  speed_ff, speed_in;
   logic [W-1:0]  accel_ff, accel_in;
   logic [W-1:0]  curv_ff, curv_in;
   logic [W-1:0]  elap_ff, elap_in;
   // transaction and scratch
   logic          step_ff, step_in;
   logic [30:0]   dt_ff, dt_in;
   logic [PW-1:0] asq_ff, asq_in;
   logic signed [XW-1:0] d_ff, d_in;
   logic signed [XW-1:0] jk_ff, jk_in;
   logic signed [XW-1:0] j_ff, j_in;
   logic signed [XW-1:0] hr_ff, hr_in;
   logic signed [XW-1:0] ha_ff, ha_in;
   logic [W-1:0]  jd_ff, jd_in;
   logic [W-1:0]  adt_ff, adt_in;
   // response register
   logic          rv_ff, rv_in;
   logic [30:0]   osp_ff, osp_in;
   logic [31:0]   oac_ff, oac_in;
   logic [31:0]   ojk_ff, ojk_in;
   logic [31:0]   ohr_ff, ohr_in;
   logic [31:0]   oha_ff, oha_in;
   logic          ost_ff, ost_in;
   logic [30:0]   oel_ff, oel_in;
   logic          osb_ff, osb_in;

   logic signed [XW-1:0] speed_x, acc_x, curv_x, elap_x, sp_x, ac_x, dt_x;
   logic signed [XW-1:0] jl_x, dec_x, opa_x, opb_x, res_x, r_x, jsel_x;
   logic signed [XW-1:0] marg_x, na_x, hi_x, lo_x, ns_x, ls_x, el_sum;
   logic signed [XW-1:0] ld_sp_x, ld_ac_x, ld_cv_x, ld_el_x;
   logic [30:0]          jl_eff, dec_eff;
   logic                 halted, neg, shift_one, near, out_free;
   logic [PW-1:0]        prod, pr, lim_p, r_p, rhs;
   logic                 mul_busy;

   assign speed_x = sx(speed_ff);
   assign acc_x   = sx(accel_ff);
   assign curv_x  = sx(curv_ff);
   assign elap_x  = sx(elap_ff);
   assign dt_x    = {{(XW-31){1'b0}}, dt_ff};
   assign jl_eff  = (jerk_max == '0) ? 31'd1 : jerk_max;
   assign dec_eff = (decel_limit == '0) ? 31'd1 : decel_limit;
   assign jl_x    = {{(XW-31){1'b0}}, jl_eff};
   assign dec_x   = {{(XW-31){1'b0}}, dec_eff};

   assign halted = (speed_x <= ONE_X) && (acc_x <= ONE_X) && (acc_x >= MONE_X);
   assign sp_x   = halted ? ZERO_X : speed_x;
   assign ac_x   = halted ? ZERO_X : acc_x;

   always_comb begin
      opa_x     = ZERO_X;
      opb_x     = ZERO_X;
      shift_one = 1'b0;
      unique case (cmd.op) inside
         jlsp_pkg::OP_ASQ: begin
            opa_x = acc_x;
            opb_x = acc_x;
         end
         jlsp_pkg::OP_MRG_Q: begin
            opa_x     = {1'b0, mag(acc_x), 1'b0} >>> 1;
            opb_x     = XW'(Q001);
            shift_one = 1'b1;
         end
         jlsp_pkg::OP_MRG_S: begin
            opa_x     = {1'b0, mag(acc_x), 1'b0} >>> 1;
            opb_x     = dt_x;
            shift_one = 1'b1;
         end
         jlsp_pkg::OP_REL_Q, jlsp_pkg::OP_REL_S: begin
            opa_x = (d_ff > ZERO_X) ? d_ff : ZERO_X;
            opb_x = jl_x <<< 1;
         end
         jlsp_pkg::OP_HR: begin
            opa_x = sp_x;
            opb_x = curv_x;
         end
         jlsp_pkg::OP_HA: begin
            opa_x = ac_x;
            opb_x = curv_x;
         end
         jlsp_pkg::OP_JD: begin
            opa_x = j_ff;
            opb_x = dt_x;
         end
         jlsp_pkg::OP_ADT: begin
            opa_x = acc_x;
            opb_x = dt_x;
         end
         jlsp_pkg::OP_JDD: begin
            opa_x     = sx(jd_ff);
            opb_x     = dt_x;
            shift_one = 1'b1;
         end
         default: begin
            opa_x = ZERO_X;
            opb_x = ZERO_X;
         end
      endcase
   end

   jlsp_mul #(.MW(MW)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .a     (mag(opa_x)),
      .b     (mag(opb_x)),
      .busy  (mul_busy),
      .prod  (prod)
   );

   // scaled, saturated signed product
   always_comb begin
      neg   = opa_x[XW-1] ^ opb_x[XW-1];
      pr    = shift_one ? (prod >> (F + 1)) : (prod >> F);
      lim_p = neg ? (VMAX_P + 1'b1) : VMAX_P;
      r_p   = (pr > lim_p) ? lim_p : pr;
      r_x   = r_p[XW-1:0];
      res_x = neg ? -r_x : r_x;
   end

   assign rhs    = acc_x[XW-1] ? asq_ff : '0;
   assign near   = (d_ff <= ZERO_X) || (prod <= rhs);
   assign jsel_x = (acc_x < MONE_X && near) ? jl_x :
                   ((acc_x > ONE_X - dec_x) ? -jl_x : ZERO_X);
   assign marg_x = (res_x < ONE_X) ? ONE_X : res_x;

   always_comb begin
      na_x = sat_w(acc_x + sx(jd_ff));
      hi_x = (acc_x > ZERO_X) ? acc_x : ZERO_X;
      lo_x = -dec_x;
      if (lo_x < VMIN_X) lo_x = VMIN_X;
      if (na_x < lo_x) na_x = lo_x;
      else if (na_x > hi_x) na_x = hi_x;
      ns_x    = sat_w(speed_x + sx(adt_ff) + res_x);
      el_sum  = sat_w(elap_x + dt_x);
      ls_x    = {{(XW-32){load_speed[31]}}, load_speed};
      ld_sp_x = sat_w(ls_x);
      ld_ac_x = sat_w({{(XW-32){load_accel[31]}}, load_accel});
      ld_cv_x = sat_w({{(XW-32){load_curvature[31]}}, load_curvature});
      ld_el_x = sat_w({{(XW-31){1'b0}}, load_elapsed});
   end

   assign out_free = !rv_ff || rsp_ready;

   always_comb begin
      speed_in = speed_ff;
      accel_in = accel_ff;
      curv_in  = curv_ff;
      elap_in  = elap_ff;
      step_in  = step_ff;
      dt_in    = dt_ff;
      asq_in   = asq_ff;
      d_in     = d_ff;
      jk_in    = jk_ff;
      j_in     = j_ff;
      hr_in    = hr_ff;
      ha_in    = ha_ff;
      jd_in    = jd_ff;
      adt_in   = adt_ff;
      rv_in    = rv_ff && !rsp_ready;
      osp_in   = osp_ff;
      oac_in   = oac_ff;
      ojk_in   = ojk_ff;
      ohr_in   = ohr_ff;
      oha_in   = oha_ff;
      ost_in   = ost_ff;
      oel_in   = oel_ff;
      osb_in   = osb_ff;

      if (cmd.load) begin
         step_in = opcode;
         dt_in   = step_time;
         if (!opcode) begin
            speed_in = ls_x[XW-1] ? '0 : ld_sp_x[W-1:0];
            accel_in = ld_ac_x[W-1:0];
            curv_in  = ld_cv_x[W-1:0];
            elap_in  = ld_el_x[W-1:0];
         end
      end

      if (cmd.wb) begin
         case (cmd.op) inside
            jlsp_pkg::OP_ASQ: asq_in = prod;
            jlsp_pkg::OP_MRG_Q, jlsp_pkg::OP_MRG_S: d_in = speed_x - marg_x;
            jlsp_pkg::OP_REL_Q: jk_in = halted ? ZERO_X : jsel_x;
            jlsp_pkg::OP_REL_S: j_in = jsel_x;
            jlsp_pkg::OP_HR: hr_in = res_x;
            jlsp_pkg::OP_HA: ha_in = res_x;
            jlsp_pkg::OP_JD: jd_in = res_x[W-1:0];
            jlsp_pkg::OP_ADT: adt_in = res_x[W-1:0];
            jlsp_pkg::OP_JDD: begin
               if (ns_x <= ZERO_X) begin
                  speed_in = '0;
                  accel_in = '0;
               end else begin
                  speed_in = ns_x[W-1:0];
                  accel_in = na_x[W-1:0];
               end
               elap_in = el_sum[W-1:0];
            end
            default: asq_in = asq_ff;
         endcase
      end

      if (cmd.emit) begin
         rv_in  = 1'b1;
         osp_in = (sp_x > O32MAX_X) ? 31'h7fffffff : sp_x[30:0];
         oac_in = sat_32(ac_x);
         ojk_in = sat_32(jk_ff);
         ohr_in = sat_32(hr_ff);
         oha_in = sat_32(ha_ff);
         ost_in = halted;
         oel_in = (elap_x > O32MAX_X) ? 31'h7fffffff : elap_x[30:0];
         osb_in = step_ff && (dt_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         accel_ff <= '0;
         curv_ff  <= '0;
         elap_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         speed_ff <= speed_in;
         accel_ff <= accel_in;
         curv_ff  <= curv_in;
         elap_ff  <= elap_in;
         rv_ff    <= rv_in;
      end
      step_ff <= step_in;
      dt_ff   <= dt_in;
      asq_ff  <= asq_in;
      d_ff    <= d_in;
      jk_ff   <= jk_in;
      j_ff    <= j_in;
      hr_ff   <= hr_in;
      ha_ff   <= ha_in;
      jd_ff   <= jd_in;
      adt_ff  <= adt_in;
      osp_ff  <= osp_in;
      oac_ff  <= oac_in;
      ojk_ff  <= ojk_in;
      ohr_ff  <= ohr_in;
      oha_ff  <= oha_in;
      ost_ff  <= ost_in;
      oel_ff  <= oel_in;
      osb_ff  <= osb_in;
   end

   assign status.mul_busy = mul_busy;
   assign status.out_free = out_free;
   assign status.advance  = step_ff && (dt_ff != '0) && !halted;

   assign rsp_valid   = rv_ff;
   assign out_speed   = osp_ff;
   assign out_accel   = oac_ff;
   assign out_jerk    = ojk_ff;
   assign yaw_rate    = ohr_ff;
   assign yaw_accel   = oha_ff;
   assign halt_flag   = ost_ff;
   assign out_elapsed = oel_ff;
   assign status_bit  = osb_ff;

endmodule

`default_nettype wire

/* design/jlsp_ctrl.sv */
// ----------------------------------------------------------------------------
// jlsp_ctrl
// Sequencer stepping the datapath through its multiply operations
// ----------------------------------------------------------------------------
`default_nettype none

module jlsp_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire jlsp_pkg::status_type  status,
   output jlsp_pkg::cmd_type          cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_START = 2'd1;
   localparam logic [1:0] ST_BUSY  = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0]       state_ff, state_in;
   jlsp_pkg::op_type op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd.load      = 1'b0;
      cmd.mul_start = 1'b0;
      cmd.wb        = 1'b0;
      cmd.emit      = 1'b0;
      cmd.op        = op_ff;
      req_ready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               op_in    = jlsp_pkg::OP_ASQ;
               state_in = ST_START;
            end
         end
         ST_START: begin
            cmd.mul_start = 1'b1;
            state_in      = ST_BUSY;
         end
         ST_BUSY: begin
            if (!status.mul_busy) begin
               cmd.wb = 1'b1;
               if (op_ff == jlsp_pkg::OP_HA) begin
                  state_in = ST_EMIT;
               end else if (op_ff == jlsp_pkg::OP_JDD) begin
                  state_in = ST_IDLE;
               end else begin
                  op_in    = op_ff + 1'b1;
                  state_in = ST_START;
               end
            end
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.advance) begin
                  op_in    = jlsp_pkg::OP_MRG_S;
                  state_in = ST_START;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= jlsp_pkg::OP_ASQ;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

endmodule

`default_nettype wire

/* design/jerk_limited_stop_profile.sv */
// ----------------------------------------------------------------------------
// jerk_limited_stop_profile
// Jerk-limited braking profile generator, signed fixed point
//
//   channel   direction  handshake              contents
//   req_if    in         valid/ready            load or step transaction
//   rsp_if    out        valid/ready            sample of the profile state
//   apb       in/out     psel/penable, pready   decel and jerk limits
//
// one serial multiplier does all products, one bit per cycle, with
// MW = max(WORD_BITS, 32) as its width
// a load or a non-advancing step runs 5 products
// an advancing step runs 10 products
// synchronous reset restores the limit registers and clears the state
// a waiting response holds the sequencer before any advance, stalling input
// ----------------------------------------------------------------------------
`default_nettype none

module jerk_limited_stop_profile #(
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   jlsp_req_if.sink                                req_if,
   jlsp_rsp_if.source                              rsp_if,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [jlsp_pkg::CFG_ADDR_BITS-1:0] paddr,
   input  wire logic [31:0]                        pwdata,
   output logic      [31:0]                        prdata,
   output logic                                    pready
);

   localparam logic [30:0] DECEL_RESET = 31'(6 << FRAC_BITS);
   localparam logic [30:0] JERK_RESET  = 31'(10 << FRAC_BITS);

   jlsp_pkg::cmd_type    cmd;
   jlsp_pkg::status_type st;
   logic [30:0]          decel_limit;
   logic [30:0]          jerk_max;

   jlsp_csr #(
      .DECEL_RESET (DECEL_RESET),
      .JERK_RESET  (JERK_RESET)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .decel_limit (decel_limit),
      .jerk_max    (jerk_max)
   );

   jlsp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (st),
      .cmd       (cmd)
   );

   jlsp_datapath #(
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (st),
      .opcode         (req_if.opcode),
      .load_speed     (req_if.load_speed),
      .load_accel     (req_if.load_accel),
      .load_curvature (req_if.load_curvature),
      .load_elapsed   (req_if.load_elapsed),
      .step_time      (req_if.step_time),
      .decel_limit    (decel_limit),
      .jerk_max       (jerk_max),
      .rsp_valid      (rsp_if.valid),
      .rsp_ready      (rsp_if.ready),
      .out_speed      (rsp_if.out_speed),
      .out_accel      (rsp_if.out_accel),
      .out_jerk       (rsp_if.out_jerk),
      .yaw_rate       (rsp_if.yaw_rate),
      .yaw_accel      (rsp_if.yaw_accel),
      .halt_flag      (rsp_if.halt_flag),
      .out_elapsed    (rsp_if.out_elapsed),
      .status_bit     (rsp_if.status)
   );

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !st.mul_busy)
      else $error("multiply started while multiplier busy");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> st.out_free)
      else $error("sample written over a pending response");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> !req_if.ready)
      else $error("new transaction taken while one is in progress");

endmodule

`default_nettype wire

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the jerk-limited braking profile generator
//
// A predictor inside a scoreboard class mirrors the limit registers and the
// profile state. It works out the sample for every accepted request
// transaction and checks each response transaction against the oldest
// expected sample. Stimulus is a short directed set and then random
// load/step sequences. These run under several limit settings and several
// patterns of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

typedef struct packed {
   bit               op;
   bit signed [31:0] spd;
   bit signed [31:0] acc;
   bit signed [31:0] curv;
   bit        [30:0] el;
   bit        [30:0] dt;
} braking_req_type;

typedef struct packed {
   bit        [30:0] speed;
   bit signed [31:0] accel;
   bit signed [31:0] jerk;
   bit signed [31:0] hrate;
   bit signed [31:0] haccel;
   bit               stopped;
   bit        [30:0] elapsed;
   bit               status;
} profile_sample_type;

class scoreboard_type;
   localparam longint VMAX = 64'sd2147483647;
   localparam longint VMIN = -VMAX - 1;
   localparam int FRAC = 16;

   longint speed_q, accel_q, curv_q, elapsed_q;
   longint decel_lim, jerk_lim;
   profile_sample_type samples_due[$];
   int errors;
   int n_checked;
   int n_invalid;
   int n_stopped;

   function new();
      speed_q = 0; accel_q = 0; curv_q = 0; elapsed_q = 0;
      decel_lim = 6 << FRAC;
      jerk_lim = 10 << FRAC;
      errors = 0; n_checked = 0; n_invalid = 0; n_stopped = 0;
   endfunction

   function void set_limit(bit idx, bit [31:0] val);
      if (idx == jlsp_pkg::REG_DECEL) decel_lim = longint'(val[30:0]);
      else jerk_lim = longint'(val[30:0]);
   endfunction

   function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function bit [63:0] magn(longint v);
      return v < 0 ? -v : v;
   endfunction

   // (a*b) >> sh, truncated toward zero, saturated to the word range
   function longint mul_shift(longint a, longint b, int sh);
      bit neg;
      bit [127:0] r;
      bit [127:0] lim;
      neg = (a < 0) != (b < 0);
      r = ({64'b0, magn(a)} * {64'b0, magn(b)}) >> sh;
      lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
      if (r > lim) r = lim;
      return neg ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function longint eff_jerk();
      return jerk_lim != 0 ? jerk_lim : 1;
   endfunction

   function longint eff_decel();
      return decel_lim != 0 ? decel_lim : 1;
   endfunction

   function bit halted();
      return speed_q <= 1 && accel_q <= 1 && accel_q >= -1;
   endfunction

   function longint jerk_choice(longint dt);
      longint margin, d, an;
      bit near;
      bit [127:0] lhs, rhs;
      if (halted()) return 0;
      margin = mul_shift(longint'(magn(accel_q)), dt, FRAC + 1);
      if (margin < 1) margin = 1;
      d = speed_q - margin;
      if (d <= 0) begin
         near = 1;
      end else begin
         an = accel_q < 0 ? -accel_q : 0;
         lhs = 128'(d) * 128'(2 * eff_jerk());
         rhs = 128'(an) * 128'(an);
         near = lhs <= rhs;
      end
      if (accel_q < -1 && near) return eff_jerk();
      if (accel_q > -eff_decel() + 1) return -eff_jerk();
      return 0;
   endfunction

   function void note(braking_req_type it);
      profile_sample_type s;
      longint sp, ac, jk, dt, j, na, hi, lo, ns, jdt;
      bit h;
      dt = longint'(it.dt);
      if (!it.op) begin
         speed_q = it.spd < 0 ? 0 : longint'(it.spd);
         accel_q = longint'(it.acc);
         curv_q = longint'(it.curv);
         elapsed_q = longint'(it.el);
      end
      h = halted();
      jk = h ? 0 : jerk_choice((65536 + 50) / 100);
      sp = h ? 0 : (speed_q < 0 ? 0 : speed_q);
      ac = h ? 0 : accel_q;
      s.speed = 31'(clamp(sp, 0, VMAX));
      s.accel = 32'(clamp(ac, VMIN, VMAX));
      s.jerk = 32'(clamp(jk, VMIN, VMAX));
      s.hrate = 32'(mul_shift(sp, curv_q, FRAC));
      s.haccel = 32'(mul_shift(ac, curv_q, FRAC));
      s.stopped = h;
      s.elapsed = 31'(clamp(elapsed_q, 0, VMAX));
      s.status = 0;
      if (h) n_stopped++;
      if (it.op) begin
         if (dt == 0) begin
            s.status = 1;
            n_invalid++;
         end else if (!h) begin
            j = jerk_choice(dt);
            jdt = mul_shift(j, dt, FRAC);
            na = clamp(accel_q + jdt, VMIN, VMAX);
            hi = accel_q > 0 ? accel_q : 0;
            lo = -eff_decel();
            if (lo < VMIN) lo = VMIN;
            na = na < lo ? lo : (na > hi ? hi : na);
            ns = speed_q + mul_shift(accel_q, dt, FRAC) + mul_shift(jdt, dt, FRAC + 1);
            ns = clamp(ns, VMIN, VMAX);
            if (ns <= 0) begin
               speed_q = 0;
               accel_q = 0;
            end else begin
               speed_q = ns;
               accel_q = na;
            end
            elapsed_q = clamp(elapsed_q + dt, 0, VMAX);
         end
      end
      samples_due = {samples_due, s};
   endfunction

   function void check(profile_sample_type act);
      profile_sample_type exp_s;
      if (samples_due.size() == 0) begin
         $display("%0t: unexpected response %p", $time, act);
         errors++;
         return;
      end
      exp_s = samples_due[0];
      samples_due.delete(0);
      n_checked++;
      if (act != exp_s) begin
         $display("%0t: mismatch expected %p", $time, exp_s);
         $display("%0t: mismatch actual   %p", $time, act);
         errors++;
      end
   endfunction

   function int count();
      return samples_due.size();
   endfunction
endclass

module testbench;

   localparam logic [jlsp_pkg::CFG_ADDR_BITS-1:0] ADDR_DECEL = {jlsp_pkg::REG_DECEL, 2'b00};
   localparam logic [jlsp_pkg::CFG_ADDR_BITS-1:0] ADDR_JERK  = {jlsp_pkg::REG_JERK, 2'b00};
   localparam bit OPC_LOAD = 1'b0;
   localparam bit OPC_STEP = 1'b1;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [jlsp_pkg::CFG_ADDR_BITS-1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   jlsp_req_if req_bus();
   jlsp_rsp_if rsp_bus();

   jerk_limited_stop_profile dut (
      .clock(clock), .reset(reset),
      .req_if(req_bus.sink), .rsp_if(rsp_bus.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   scoreboard_type sb;
   int idle_pct;
   int stall_pct;
   int hold_cycles;
   int n_sent;
   int n_cfg;

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("testbench: done, errors");
      $finish;
   end

   // response side: ready driven at the falling edge
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      profile_sample_type act;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         act.speed = rsp_bus.out_speed;
         act.accel = rsp_bus.out_accel;
         act.jerk = rsp_bus.out_jerk;
         act.hrate = rsp_bus.yaw_rate;
         act.haccel = rsp_bus.yaw_accel;
         act.stopped = rsp_bus.halt_flag;
         act.elapsed = rsp_bus.out_elapsed;
         act.status = rsp_bus.status;
         sb.check(act);
      end
   end

   task automatic send(braking_req_type it);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.opcode <= it.op;
      req_bus.load_speed <= it.spd;
      req_bus.load_accel <= it.acc;
      req_bus.load_curvature <= it.curv;
      req_bus.load_elapsed <= it.el;
      req_bus.step_time <= it.dt;
      do @(posedge clock); while (!req_bus.ready);
      sb.note(it);
      n_sent++;
   endtask

   task automatic send_load(int spd, int acc, int curv, int el);
      braking_req_type it;
      it.op = OPC_LOAD; it.spd = spd; it.acc = acc; it.curv = curv;
      it.el = 31'(el); it.dt = 31'($urandom);
      send(it);
   endtask

   task automatic send_step(bit [30:0] dt);
      braking_req_type it;
      it.op = OPC_STEP; it.spd = $urandom; it.acc = $urandom; it.curv = $urandom;
      it.el = 31'($urandom); it.dt = dt;
      send(it);
   endtask

   // waits for every response and for the block to go idle
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (sb.count() != 0 || !req_bus.ready) @(posedge clock);
   endtask

   task automatic csr_write(logic [jlsp_pkg::CFG_ADDR_BITS-1:0] addr, logic [31:0] data);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      sb.set_limit(addr == ADDR_JERK, data);
      @(negedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      n_cfg++;
   endtask

   task automatic csr_read_check(logic [jlsp_pkg::CFG_ADDR_BITS-1:0] addr,
                                 logic [31:0] want);
      @(negedge clock);
      psel <= 1; penable <= 0; pwrite <= 0; paddr <= addr;
      @(negedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      if (prdata !== want) begin
         $display("%0t: register read at %0d expected %h actual %h",
                  $time, addr, want, prdata);
         sb.errors++;
      end
      @(negedge clock);
      psel <= 0; penable <= 0;
   endtask

   task automatic set_limits(logic [31:0] decel, logic [31:0] jerk);
      csr_write(ADDR_DECEL, decel);
      csr_write(ADDR_JERK, jerk);
      csr_read_check(ADDR_DECEL, {1'b0, decel[30:0]});
      csr_read_check(ADDR_JERK, {1'b0, jerk[30:0]});
   endtask

   task automatic random_traffic(int n);
      int k, len;
      bit [30:0] dt;
      k = 0;
      while (k < n) begin
         if ($urandom_range(99) < 15) begin
            if ($urandom_range(1)) send_step(31'($urandom));
            else send_load($urandom, $urandom, $urandom, $urandom);
            k++;
         end else begin
            send_load($urandom_range(0, 40 << 16),
                      int'($urandom_range(0, 10 << 16)) - (8 << 16),
                      int'($urandom_range(0, 1 << 16)) - (1 << 15),
                      $urandom_range(0, 1000 << 16));
            k++;
            len = $urandom_range(5, 30);
            repeat (len) begin
               case ($urandom_range(99)) inside
                  [0:4]: dt = 31'd0;
                  [5:7]: dt = 31'($urandom);
                  default: dt = 31'($urandom_range(300, 20000));
               endcase
               send_step(dt);
               k++;
            end
         end
      end
   endtask

   initial begin
      int ph;
      logic [31:0] dl, jl;
      sb = new();
      idle_pct = 0; stall_pct = 0; hold_cycles = 0; n_sent = 0; n_cfg = 0;
      reset = 1;
      psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
      req_bus.valid = 0; req_bus.opcode = 0; req_bus.load_speed = 0;
      req_bus.load_accel = 0; req_bus.load_curvature = 0;
      req_bus.load_elapsed = 0; req_bus.step_time = 0;
      rsp_bus.ready = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: step from reset, extremes, zero step, negative speed, stopped
      send_step(31'd655);
      send_load(32'h7fffffff, 32'h80000000, 32'h7fffffff, 31'h7fffffff);
      send_step(31'h7fffffff);
      send_load(32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'h7ffffff0);
      send_step(31'd0);
      send_step(31'd1);
      send_load(32'h80000000, 32'h00000001, 32'h00010000, 31'd0);
      send_step(31'd655);
      send_load(-(5 << 16), -(3 << 16), 32'h00010000, 31'd100);
      send_step(31'd655);
      send_load(1, -1, 32'h7fffffff, 31'd5);
      send_step(31'd6553);
      send_load(20 << 16, -(6 << 16), -(1 << 14), 31'd0);
      send_step(31'd6553);
      send_step(31'd6553);
      send_load(2, 0, 0, 31'd0);
      send_step(31'd65536);
      send_load(1 << 16, -(6 << 16), 0, 31'd0);
      send_step(31'd655);
      send_step(31'd655);
      send_load(10 << 16, 2 << 16, 32'h00008000, 31'd0);
      send_step(31'd13107);
      drain();

      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin dl = 32'h7fffffff; jl = 32'h7fffffff; end
            1: begin dl = 32'd1; jl = 32'd1; end
            2: begin dl = 32'd0; jl = 32'd0; end
            3: begin dl = 32'd393216; jl = 32'd655360; end
            default: begin
               dl = $urandom_range(1 << 14, 12 << 16) | (32'($urandom_range(1)) << 31);
               jl = $urandom_range(1 << 14, 30 << 16);
            end
         endcase
         set_limits(dl, jl);
         case (ph % 4)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 65; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 65; end
            default: begin idle_pct = 36; stall_pct = 36; end
         endcase
         if (ph == 4) begin
            random_traffic(20);
            hold_cycles = 3000;
            random_traffic(20);
            drain();
            random_traffic(20);
         end
         random_traffic(200);
         drain();
      end
      set_limits(32'd393216, 32'd655360);

      drain();
      repeat (400) @(posedge clock);
      if (sb.count() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, sb.count());
         sb.errors++;
      end
      $display("covered %0d requests, %0d responses checked, %0d limit writes",
               n_sent, sb.n_checked, n_cfg);
      $display("zero-step samples %0d, stopped samples %0d", sb.n_invalid, sb.n_stopped);
      if (sb.errors == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

`default_nettype wire

/* jerk_limited_stop_profile.f */
design/jlsp_pkg.sv
design/jlsp_req_if.sv
design/jlsp_rsp_if.sv
design/jlsp_csr.sv
design/jlsp_mul.sv
design/jlsp_datapath.sv
design/jlsp_ctrl.sv
design/jerk_limited_stop_profile.sv
test/testbench.sv
